### hw/rtl/multi_class_priority_deque_core_macros.svh
// Assertion macros for the multi-class priority deque core.
// Used by the top level; compiled out when NO_ASSERTIONS is defined.
`ifndef MULTI_CLASS_PRIORITY_DEQUE_CORE_MACROS_SVH
`define MULTI_CLASS_PRIORITY_DEQUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define MCPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCPD_ASSERT_NOW(label, ante, cons, msg)
`define MCPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/mcpd_pkg.sv
// Shared types, sizes and helpers for the multi-class priority deque core.
// No dependencies; imported by mcpd_cell and the top level.
`default_nettype none

package mcpd_pkg;

    // Sizing
    localparam int NUM_CLASSES = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_BITS    = 16;

    // Fixed field widths of the item ports
    localparam int CLASS_W  = 5;
    localparam int PTAG_W   = 16;
    localparam int PLEN_W   = 4;

    // Derived widths
    localparam int ID_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MATCH_W = (ID_W > CLASS_W) ? ID_W : CLASS_W;
    localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Request plus the result it collects while walking the cell chain
    typedef struct packed {
        op_t                 op;
        logic [CLASS_W-1:0]  cls;
        logic [TAG_BITS-1:0] tag;
        logic                urgent;
        status_t             status;
        logic [TAG_BITS-1:0] otag;
        logic                ourg;
        logic [LEN_W-1:0]    olen;
    } mcpd_req_t;

    // Port tag -> stored tag (mask or zero-extend)
    function automatic logic [TAG_BITS-1:0] tag_in(logic [PTAG_W-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[TAG_BITS-1:0];
    endfunction

    // Stored tag -> port tag
    function automatic logic [PTAG_W-1:0] tag_out(logic [TAG_BITS-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[PTAG_W-1:0];
    endfunction

    // Queue length -> 4-bit port field
    function automatic logic [PLEN_W-1:0] len_out(logic [LEN_W-1:0] l);
        logic [63:0] w;
        w = 64'(l);
        return w[PLEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mcpd_cell.sv
// One class cell: holds a class queue as a shift deque (front at slot 0)
// and its length. Depends on mcpd_pkg.
`default_nettype none

module mcpd_cell
    import mcpd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic [ID_W-1:0]  cell_id,
    input  wire logic             req_valid_in,
    input  wire mcpd_req_t        req_in,
    output logic                  req_valid_out,
    output mcpd_req_t             req_out
);

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [TAG_BITS-1:0] slot_tag_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] slot_tag_next [QUEUE_DEPTH];
    logic                slot_urg_reg [QUEUE_DEPTH];
    logic                slot_urg_next [QUEUE_DEPTH];
    logic                req_valid_reg;
    mcpd_req_t           req_reg, req_next;

    logic hit, is_full, is_empty, enq_ok, deq_ok;

    // Operation decode for this class
    assign hit      = req_valid_in && (MATCH_W'(req_in.cls) == MATCH_W'(cell_id));
    assign is_full  = (len_reg >= LEN_W'(QUEUE_DEPTH));
    assign is_empty = (len_reg == '0);
    assign enq_ok   = hit && (req_in.op == OP_ENQ) && !is_full;
    assign deq_ok   = hit && (req_in.op == OP_DEQ) && !is_empty;

    // Slot update: urgent push shifts back, regular push fills slot len,
    // pop shifts forward
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_tag_next[i] = slot_tag_reg[i];
            slot_urg_next[i] = slot_urg_reg[i];
            if (enq_ok && req_in.urgent)
            begin
                if (i == 0)
                begin
                    slot_tag_next[i] = req_in.tag;
                    slot_urg_next[i] = 1'b1;
                end
                else
                begin
                    slot_tag_next[i] = slot_tag_reg[i-1];
                    slot_urg_next[i] = slot_urg_reg[i-1];
                end
            end
            else if (enq_ok)
            begin
                if (LEN_W'(i) == len_reg)
                begin
                    slot_tag_next[i] = req_in.tag;
                    slot_urg_next[i] = 1'b0;
                end
            end
            else if (deq_ok && (i < QUEUE_DEPTH - 1))
            begin
                slot_tag_next[i] = slot_tag_reg[i+1];
                slot_urg_next[i] = slot_urg_reg[i+1];
            end
        end
    end

    // Length update and result for a matching item
    always_comb
    begin
        len_next = len_reg;
        req_next = req_in;
        if (hit)
        begin
            case (req_in.op)
                OP_ENQ:
                begin
                    if (is_full)
                    begin
                        req_next.status = ST_FULL;
                        req_next.olen   = len_reg;
                    end
                    else
                    begin
                        len_next        = len_reg + LEN_W'(1);
                        req_next.status = ST_DONE;
                        req_next.olen   = len_reg + LEN_W'(1);
                    end
                end
                OP_DEQ:
                begin
                    if (is_empty)
                    begin
                        req_next.status = ST_EMPTY;
                        req_next.olen   = '0;
                    end
                    else
                    begin
                        len_next        = len_reg - LEN_W'(1);
                        req_next.status = ST_DONE;
                        req_next.otag   = slot_tag_reg[0];
                        req_next.ourg   = slot_urg_reg[0];
                        req_next.olen   = len_reg - LEN_W'(1);
                    end
                end
                default:
                begin
                    req_next = req_in;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            req_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            len_reg       <= len_next;
            req_valid_reg <= req_valid_in;
        end
    end

    // Payload and storage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg <= req_next;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_tag_reg[i] <= slot_tag_next[i];
                slot_urg_reg[i] <= slot_urg_next[i];
            end
        end
    end

    assign req_valid_out = req_valid_reg;
    assign req_out       = req_reg;

endmodule

`default_nettype wire

### hw/rtl/multi_class_priority_deque_core.sv
// Top level of the multi-class priority deque: a chain of class cells.
// Depends on mcpd_pkg, mcpd_cell and multi_class_priority_deque_core_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | op, class_index, entry_tag, urgent
//   out     | out_valid / out_stall| result_status, out_tag, out_urgent, length_after
//
// An item walks the chain one cell per cycle while the chain is not stalled, registered in every cell,
// and one item is taken per cycle while in_stall is low, set by the one-cell-per-stage chain.
// The cell of the addressed class does the queue update as the item passes it.
// Reset clears all queue lengths at once; no clearing pass is needed.
// A stalled result at the chain end freezes every cell and stalls the input.
`default_nettype none

`include "multi_class_priority_deque_core_macros.svh"

module multi_class_priority_deque_core
    import mcpd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               op,
    input  wire logic [CLASS_W-1:0] class_index,
    input  wire logic [PTAG_W-1:0]  entry_tag,
    input  wire logic               urgent,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              result_status,
    output logic [PTAG_W-1:0]       out_tag,
    output logic                    out_urgent,
    output logic [PLEN_W-1:0]       length_after
);

    logic      chain_valid [NUM_CLASSES+1];
    mcpd_req_t chain_req   [NUM_CLASSES+1];
    logic      adv;

    // Whole chain moves unless a finished item waits at the end
    assign adv      = !(chain_valid[NUM_CLASSES] && out_stall);
    assign in_stall = !adv;

    // Entry: default result covers classes with no cell
    always_comb
    begin
        chain_valid[0]      = in_valid;
        chain_req[0].op     = op_t'(op);
        chain_req[0].cls    = class_index;
        chain_req[0].tag    = tag_in(entry_tag);
        chain_req[0].urgent = urgent;
        chain_req[0].status = (op_t'(op) == OP_DEQ) ? ST_EMPTY : ST_FULL;
        chain_req[0].otag   = '0;
        chain_req[0].ourg   = 1'b0;
        chain_req[0].olen   = '0;
    end

    // Cell chain, one cell per class
    for (genvar k = 0; k < NUM_CLASSES; k++)
    begin : g_cell
        mcpd_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .cell_id       (ID_W'(k)),
            .req_valid_in  (chain_valid[k]),
            .req_in        (chain_req[k]),
            .req_valid_out (chain_valid[k+1]),
            .req_out       (chain_req[k+1])
        );
    end

    // Result ports
    assign out_valid     = chain_valid[NUM_CLASSES];
    assign result_status = chain_req[NUM_CLASSES].status;
    assign out_tag       = tag_out(chain_req[NUM_CLASSES].otag);
    assign out_urgent    = chain_req[NUM_CLASSES].ourg;
    assign length_after  = len_out(chain_req[NUM_CLASSES].olen);

    // Checks
    `MCPD_ASSERT_NOW(a_stall_freeze, out_valid && out_stall, in_stall, "input not stalled while output held")
    `MCPD_ASSERT_NEXT(a_enter_chain, in_valid && !in_stall, chain_valid[1], "accepted item did not enter chain")
    `MCPD_ASSERT_NOW(a_empty_result, out_valid && (result_status == ST_EMPTY), (length_after == '0) && (out_tag == '0) && !out_urgent, "empty result carries data")
    `MCPD_ASSERT_NOW(a_full_result, out_valid && (result_status == ST_FULL), (out_tag == '0) && !out_urgent, "rejected enqueue carries data")

endmodule

`default_nettype wire
